// ===== hw/rtl/stereogram_disparity_search_core_macros.svh =====
// ----------------------------------------------------------------------------
// Stereogram disparity search core assertion macros
// Shared concurrent assertion forms, clocked on aclk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef STEREOGRAM_DISPARITY_SEARCH_CORE_MACROS_SVH
`define STEREOGRAM_DISPARITY_SEARCH_CORE_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define SDS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define SDS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sds_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereogram disparity search package
// Sizes, codes and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package sds_pkg;

    // Line store and window limits
    localparam int MAX_LINE   = 1024;
    localparam int MAX_WINDOW = 6;
    localparam int ADDR_W     = $clog2(MAX_LINE);
    localparam int SIZE_W     = $clog2(MAX_WINDOW + 1);

    // Field and internal widths
    localparam int PERIOD_W    = 10;
    localparam int LWIDTH_W    = 11;
    localparam int COL_W       = 10;
    localparam int CHAN_W      = 8;
    localparam int PIX_W       = 3 * CHAN_W;
    localparam int OFF_W       = 11;
    localparam int POS_W       = 12;
    localparam int LIM_W       = 15;
    localparam int REM_W       = OFF_W + SIZE_W;
    localparam int SCORE_W     = 16;
    localparam int DIFF_W      = CHAN_W + 2;
    localparam int DISP_W      = 11;
    localparam int WIN_W       = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;

    // Divide by three: floor(x * RECIP3 / 2**RECIP3_SHIFT) for x below 2**16
    localparam int RECIP3_W     = 16;
    localparam int RECIP3_SHIFT = 17;
    localparam logic [RECIP3_W-1:0] RECIP3 = 16'hAAAB;

    // Register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd64;
    localparam logic [LWIDTH_W-1:0] LWIDTH_RESET = 11'd1024;

    // Item kinds carried on s_tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LWIDTH = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic mem_wr;       // store the incoming pixel
        logic query_load;   // latch column and period, start at the widest window
        logic setup;        // derive start offset and scan limit
        logic size_init;    // rewind candidate offset, forget best score
        logic cand_clr;     // clear counter and accumulator for a candidate
        logic cand_run;     // read pixels, accumulate, divide
        logic cand_update;  // compare score, advance offset
        logic size_dec;     // step to the next smaller window
        logic out_load;     // move the result into the output register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic cand_ok;      // candidate offset passes both scan limits
        logic cand_last;    // last cycle of the candidate evaluation
        logic hit;          // best score of this window is under threshold
        logic size_one;     // current window is the smallest
        logic out_busy;     // output register holds an untaken result
    } dp_status_t;

endpackage

// ===== hw/rtl/sds_datapath.sv =====
// ----------------------------------------------------------------------------
// Stereogram disparity search datapath
// Line store, window SAD accumulator, distance penalty divider, best-score
// tracking, configuration registers and the result output register.
// ----------------------------------------------------------------------------
module sds_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sds_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [sds_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [sds_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  sds_pkg::dp_cmd_t                cmd,
    output sds_pkg::dp_status_t             status,
    output logic                            m_tvalid,
    output logic [sds_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tuser,
    input  logic                            m_tready
);
    import sds_pkg::*;

    // Configuration
    logic [PERIOD_W-1:0] period_reg;
    logic [LWIDTH_W-1:0] lwidth_reg;

    // Query context
    logic [COL_W-1:0]    j_reg;
    logic [PERIOD_W-1:0] p_reg;
    logic [OFF_W-1:0]    start_off_reg;
    logic [LIM_W-1:0]    limit_reg;
    logic [OFF_W-1:0]    off_reg;
    logic [SIZE_W-1:0]   size_reg;

    // Candidate evaluation
    logic [SIZE_W-1:0]   cnt_reg;
    logic                rd_valid_reg;
    logic [PIX_W-1:0]    rd_a_reg;
    logic [PIX_W-1:0]    rd_b_reg;
    logic                rd_oob_a_reg;
    logic                rd_oob_b_reg;
    logic [SCORE_W-1:0]  acc_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [SIZE_W-1:0]   quo_reg;

    // Best candidate of the current window
    logic                      have_reg;
    logic [SCORE_W-1:0]        best_reg;
    logic signed [DISP_W-1:0]  best_rel_reg;

    // Output register
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic                   m_tuser_reg;

    // Line store
    logic [PIX_W-1:0] mem [MAX_LINE];

    // Input fields
    logic [COL_W-1:0]  in_col;
    logic [PIX_W-1:0]  in_pix;

    // Combinational helpers
    logic [POS_W-1:0]          l_pos;
    logic [POS_W-1:0]          end_pos;
    logic [LIM_W-1:0]          ten_off;
    logic [LIM_W-1:0]          limit_next;
    logic [OFF_W-1:0]          start_next;
    logic [OFF_W+RECIP3_W-1:0] recip_prod;
    logic signed [POS_W-1:0]   rel;
    logic [OFF_W-1:0]          pen_dist;
    logic [SIZE_W-1:0]         last_cnt;
    logic [POS_W-1:0]          rd_pos_a;
    logic [POS_W-1:0]          rd_pos_b;
    logic [ADDR_W-1:0]         rd_addr_a;
    logic [ADDR_W-1:0]         rd_addr_b;
    logic [PIX_W-1:0]          pix_a;
    logic [PIX_W-1:0]          pix_b;
    logic [DIFF_W-1:0]         diff_sum;
    logic [SIZE_W-1:0]         step_sh;
    logic [REM_W-1:0]          p_sh;
    logic                      div_ge;
    logic                      div_load;
    logic                      div_step;
    logic [SCORE_W-1:0]        score;
    logic [SCORE_W-1:0]        thresh;
    logic                      hit;
    logic [DISP_W-1:0]         res_disp;
    logic [WIN_W-1:0]          res_win;

    function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

    assign in_col = s_tdata[COL_W-1:0];
    assign in_pix = {s_tdata[COL_W +: CHAN_W],
                     s_tdata[COL_W + CHAN_W +: CHAN_W],
                     s_tdata[COL_W + 2*CHAN_W +: CHAN_W]};

    // Candidate position and scan limits
    assign l_pos   = POS_W'(j_reg) + POS_W'(off_reg);
    assign end_pos = l_pos + POS_W'(size_reg);
    assign ten_off = (LIM_W'(off_reg) << 3) + (LIM_W'(off_reg) << 1);

    // Setup: start offset (2p)/3 by reciprocal, limit 13p
    assign recip_prod = (OFF_W+RECIP3_W)'({p_reg, 1'b0}) * (OFF_W+RECIP3_W)'(RECIP3);
    assign start_next = OFF_W'(recip_prod[OFF_W+RECIP3_W-1:RECIP3_SHIFT]);
    assign limit_next = (LIM_W'(p_reg) << 3) + (LIM_W'(p_reg) << 2) + LIM_W'(p_reg);

    // Offset from period and its magnitude
    assign rel      = signed'(POS_W'(off_reg)) - signed'(POS_W'(p_reg));
    assign pen_dist = rel[POS_W-1] ? OFF_W'(-rel) : OFF_W'(rel);

    // A candidate runs until both the reads and the divider are through
    assign last_cnt = (size_reg > SIZE_W'(SIZE_W)) ? size_reg : SIZE_W'(SIZE_W);

    // Read positions for window element cnt; beyond the store reads as zero
    assign rd_pos_a  = POS_W'(j_reg) + POS_W'(cnt_reg);
    assign rd_pos_b  = l_pos + POS_W'(cnt_reg);
    assign rd_addr_a = rd_pos_a[ADDR_W-1:0];
    assign rd_addr_b = rd_pos_b[ADDR_W-1:0];
    assign pix_a     = rd_oob_a_reg ? '0 : rd_a_reg;
    assign pix_b     = rd_oob_b_reg ? '0 : rd_b_reg;

    // RGB absolute difference of the returned pair
    assign diff_sum = DIFF_W'(absdiff(pix_a[2*CHAN_W +: CHAN_W], pix_b[2*CHAN_W +: CHAN_W]))
                    + DIFF_W'(absdiff(pix_a[CHAN_W +: CHAN_W], pix_b[CHAN_W +: CHAN_W]))
                    + DIFF_W'(absdiff(pix_a[0 +: CHAN_W], pix_b[0 +: CHAN_W]));

    // Restoring division of size*distance by period, one quotient bit per cycle
    assign div_load = cmd.cand_run && (cnt_reg == '0);
    assign div_step = cmd.cand_run && (cnt_reg != '0) && (cnt_reg <= SIZE_W'(SIZE_W));
    assign step_sh  = SIZE_W'(SIZE_W) - cnt_reg;
    assign p_sh     = REM_W'(p_reg) << step_sh;
    assign div_ge   = rem_reg >= p_sh;

    // Score, threshold and result fields
    assign score    = acc_reg + SCORE_W'(quo_reg);
    assign thresh   = (SCORE_W'(size_reg) << 1) + SCORE_W'(size_reg);
    assign hit      = have_reg && (best_reg < thresh);
    assign res_disp = hit ? best_rel_reg : '0;
    assign res_win  = hit ? WIN_W'(size_reg) : '0;

    // Status to the controller
    assign status.cand_ok   = (ten_off < limit_reg) && (end_pos < POS_W'(lwidth_reg));
    assign status.cand_last = (cnt_reg == last_cnt);
    assign status.hit       = hit;
    assign status.size_one  = (size_reg == SIZE_W'(1));
    assign status.out_busy  = m_tvalid_reg && !m_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
            lwidth_reg <= LWIDTH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_PERIOD: period_reg <= cfg_wdata[PERIOD_W-1:0];
                CFG_LWIDTH: lwidth_reg <= cfg_wdata[LWIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Line store: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (cmd.mem_wr && (32'(in_col) < MAX_LINE)) begin
            mem[ADDR_W'(in_col)] <= in_pix;
        end
        rd_a_reg     <= mem[rd_addr_a];
        rd_b_reg     <= mem[rd_addr_b];
        rd_oob_a_reg <= (rd_pos_a >= POS_W'(MAX_LINE));
        rd_oob_b_reg <= (rd_pos_b >= POS_W'(MAX_LINE));
    end

    // Query context and scan position
    always_ff @(posedge aclk) begin
        if (cmd.query_load) begin
            j_reg    <= in_col;
            p_reg    <= (period_reg == '0) ? PERIOD_W'(1) : period_reg;
            size_reg <= SIZE_W'(MAX_WINDOW);
        end
        if (cmd.setup) begin
            start_off_reg <= start_next;
            limit_reg     <= limit_next;
        end
        if (cmd.size_init) begin
            off_reg <= start_off_reg;
        end else if (cmd.cand_update) begin
            off_reg <= off_reg + OFF_W'(1);
        end
        if (cmd.size_dec) begin
            size_reg <= size_reg - SIZE_W'(1);
        end
    end

    // Candidate counter and read tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.cand_run && (cnt_reg < size_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cand_clr) begin
            cnt_reg <= '0;
        end else if (cmd.cand_run && !status.cand_last) begin
            cnt_reg <= cnt_reg + SIZE_W'(1);
        end
    end

    // Accumulate window SAD
    always_ff @(posedge aclk) begin
        if (cmd.cand_clr) begin
            acc_reg <= '0;
        end else if (rd_valid_reg) begin
            acc_reg <= acc_reg + SCORE_W'(diff_sum);
        end
    end

    // Distance penalty divider
    always_ff @(posedge aclk) begin
        if (div_load) begin
            rem_reg <= REM_W'(size_reg) * REM_W'(pen_dist);
            quo_reg <= '0;
        end else if (div_step) begin
            if (div_ge) begin
                rem_reg <= rem_reg - p_sh;
            end
            quo_reg <= (quo_reg << 1) | SIZE_W'(div_ge);
        end
    end

    // Track the first strict minimum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else if (cmd.size_init) begin
            have_reg <= 1'b0;
        end else if (cmd.cand_update && (!have_reg || score < best_reg)) begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cand_update && (!have_reg || score < best_reg)) begin
            best_reg     <= score;
            best_rel_reg <= DISP_W'(rel);
        end
    end

    // Output register: load on finish, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= OUT_TDATA_W'({res_win, res_disp});
            m_tuser_reg <= hit;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hw/rtl/sds_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stereogram disparity search controller
// Sequences one query through window sizes and candidate offsets.
// ----------------------------------------------------------------------------
module sds_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tuser,
    output logic                s_tready,
    output sds_pkg::dp_cmd_t    cmd,
    input  sds_pkg::dp_status_t status
);
    import sds_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SIZE_START,
        ST_CHECK,
        ST_CAND,
        ST_CAND_END,
        ST_SIZE_END,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == CMD_QUERY) begin
                        cmd.query_load = 1'b1;
                        state_next     = ST_SETUP;
                    end else begin
                        cmd.mem_wr = 1'b1;
                    end
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_SIZE_START;
            end
            ST_SIZE_START: begin
                cmd.size_init = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.cand_ok) begin
                    cmd.cand_clr = 1'b1;
                    state_next   = ST_CAND;
                end else begin
                    state_next = ST_SIZE_END;
                end
            end
            ST_CAND: begin
                cmd.cand_run = 1'b1;
                if (status.cand_last) begin
                    state_next = ST_CAND_END;
                end
            end
            ST_CAND_END: begin
                cmd.cand_update = 1'b1;
                state_next      = ST_CHECK;
            end
            ST_SIZE_END: begin
                if (status.hit || status.size_one) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.size_dec = 1'b1;
                    state_next   = ST_SIZE_START;
                end
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/stereogram_disparity_search_core.sv =====
// ----------------------------------------------------------------------------
// Stereogram disparity search core
// SAD block matching along one image row held in an on-chip line store.
// ----------------------------------------------------------------------------
// A pixel write (s_tuser low) is stored when taken. A query (s_tuser high) runs
// through window sizes 6 down to 1 until one matches, and per size through
// about 0.63*period candidate offsets. For each candidate the window is read
// one pixel pair per cycle from the two read ports of the line store while a
// three-step divider works out the distance penalty, then the score is
// compared. One item is worked on at a time; the next item is taken while a
// result still waits in the output register. Line store entries never
// written read as undefined.
`include "stereogram_disparity_search_core_macros.svh"

module stereogram_disparity_search_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [sds_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [sds_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // item input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sds_pkg::IN_TDATA_W-1:0]  s_tdata,   // column, red, green, blue, zero pad
    input  logic                            s_tuser,   // cmd
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sds_pkg::OUT_TDATA_W-1:0] m_tdata,   // disparity, window_used, zero pad
    output logic                            m_tuser    // matched
);
    import sds_pkg::*;

    dp_cmd_t    ctrl_cmd;
    dp_status_t dp_status;

    // Sequencer
    sds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .cmd      (ctrl_cmd),
        .status   (dp_status)
    );

    // Store, arithmetic and output register
    sds_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (ctrl_cmd),
        .status    (dp_status),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tready  (m_tready)
    );

    // A finished query shows up on the output the next cycle
    `SDS_ASSERT_NXT(a_load_shows, ctrl_cmd.out_load, m_tvalid, "result load lost")
    // Loading a result and taking an input never coincide
    `SDS_ASSERT_IMP(a_load_excl, ctrl_cmd.out_load, !s_tready, "load while accepting")
    // A match always names its window
    `SDS_ASSERT_IMP(a_match_win, m_tvalid && m_tuser, m_tdata[DISP_W +: WIN_W] != '0, "no window")
    // A miss carries zeros
    `SDS_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser, m_tdata == '0, "miss with nonzero data")

endmodule
